FILE: design/rhc_pkg.sv
package rhc_pkg;

   localparam int ChanW  = 8;
   localparam int OutW   = 16;
   localparam int QuotW  = 17;
   localparam int DivW   = 12;
   localparam int NumW   = 11;
   localparam int SumW   = 9;
   localparam int DivSteps = QuotW;

   typedef struct packed {
      logic [DivW-1:0]  rem;
      logic [QuotW-1:0] num;
      logic [DivW-1:0]  div;
   } lane_type;

   // one restoring step: shift in the next numerator bit, subtract if it fits
   function automatic lane_type div_step(lane_type l);
      logic [DivW:0] trial;
      lane_type      o;
      trial = {l.rem, l.num[QuotW-1]};
      o = l;
      if (trial >= {1'b0, l.div}) begin
         o.rem = DivW'(trial - {1'b0, l.div});
         o.num = {l.num[QuotW-2:0], 1'b1};
      end else begin
         o.rem = trial[DivW-1:0];
         o.num = {l.num[QuotW-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage

FILE: design/rgb_to_hsl_converter_core.sv
// RGB to HSL pixel converter. One pixel can enter every clock while the result
// side does not stall. Two stages find max, min, sector and the rounding terms;
// seventeen stages of restoring division, one quotient bit each, form hue and
// saturation together. A stall holds only the stages that are full, so bubbles
// close up.
module rgb_to_hsl_converter_core import rhc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [ChanW-1:0] req_red_in,
   input  logic [ChanW-1:0] req_green_in,
   input  logic [ChanW-1:0] req_blue_in,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [OutW-1:0] rsp_hue_out,
   output logic [OutW-1:0] rsp_saturation_out,
   output logic [OutW-1:0] rsp_lightness_out
);

   // front stage
   logic               vld1_ff;
   logic [ChanW-1:0]   d1_ff, den1_ff;
   logic [SumW-1:0]    sum1_ff;
   logic [NumW-1:0]    n1_ff;
   logic               grey1_ff;
   logic [ChanW-1:0]   mx, mn, d_in, den_in;
   logic [SumW-1:0]    sum_in;
   logic signed [NumW+1:0] n_raw, n_fix;
   logic               en1;

   // division stages, index 0 is the set-up stage
   logic               vld_ff  [0:DivSteps];
   lane_type           hue_ff  [0:DivSteps];
   lane_type           sat_ff  [0:DivSteps];
   logic [SumW-1:0]    sum_ff  [0:DivSteps];
   logic               grey_ff [0:DivSteps];
   logic               en      [0:DivSteps];
   lane_type           hue_in, sat_in;
   logic [27:0]        sat_num;
   logic [16:0]        light;

   always_comb begin
      mx = req_red_in;
      mn = req_red_in;
      if (req_green_in > mx) mx = req_green_in;
      if (req_blue_in > mx)  mx = req_blue_in;
      if (req_green_in < mn) mn = req_green_in;
      if (req_blue_in < mn)  mn = req_blue_in;
      d_in   = mx - mn;
      sum_in = {1'b0, mx} + {1'b0, mn};
      den_in = (sum_in < SumW'(255)) ? sum_in[ChanW-1:0] : ChanW'(SumW'(510) - sum_in);
      if (req_red_in >= mx)
         n_raw = $signed({5'd0, req_green_in}) - $signed({5'd0, req_blue_in});
      else if (req_green_in >= mx)
         n_raw = $signed({4'd0, d_in, 1'b0}) + $signed({5'd0, req_blue_in})
               - $signed({5'd0, req_red_in});
      else
         n_raw = $signed({3'd0, d_in, 2'b0}) + $signed({5'd0, req_red_in})
               - $signed({5'd0, req_green_in});
      // wrap a negative hue by one full turn
      n_fix = n_raw;
      if (n_raw < 0)
         n_fix = n_raw + $signed({3'd0, d_in, 2'b0}) + $signed({4'd0, d_in, 1'b0});
   end

   assign en1       = !vld1_ff || en[0];
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (en1) begin
         vld1_ff <= req_valid;
      end
      if (en1) begin
         d1_ff    <= d_in;
         den1_ff  <= den_in;
         sum1_ff  <= sum_in;
         n1_ff    <= n_fix[NumW-1:0];
         grey1_ff <= (d_in == '0);
      end
   end

   // rounded quotient as floor((2N + D) / 2D)
   always_comb begin
      sat_num     = {3'd0, d1_ff, 17'd0} - {19'd0, d1_ff, 1'b0} + {20'd0, den1_ff};
      hue_in.rem  = {1'b0, n1_ff};
      hue_in.num  = {8'd0, d1_ff, 1'b0} + {7'd0, d1_ff, 2'b0};
      hue_in.div  = {2'd0, d1_ff, 2'b0} + {1'b0, d1_ff, 3'b0};
      sat_in.rem  = {1'b0, sat_num[27:17]};
      sat_in.num  = sat_num[16:0];
      sat_in.div  = {3'd0, den1_ff, 1'b0};
   end

   assign en[DivSteps] = !vld_ff[DivSteps] || !rsp_stall;

   genvar k;
   generate
      for (k = 0; k < DivSteps; k++) begin : g_en
         assign en[k] = !vld_ff[k] || en[k+1];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en[0]) begin
         vld_ff[0] <= vld1_ff;
      end
      if (en[0]) begin
         hue_ff[0]  <= hue_in;
         sat_ff[0]  <= sat_in;
         sum_ff[0]  <= sum1_ff;
         grey_ff[0] <= grey1_ff;
      end
   end

   generate
      for (k = 1; k <= DivSteps; k++) begin : g_div
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
            if (en[k]) begin
               hue_ff[k]  <= div_step(hue_ff[k-1]);
               sat_ff[k]  <= div_step(sat_ff[k-1]);
               sum_ff[k]  <= sum_ff[k-1];
               grey_ff[k] <= grey_ff[k-1];
            end
         end
      end
   endgenerate

   assign light              = {8'd0, sum_ff[DivSteps]} + {sum_ff[DivSteps], 8'd0} + 17'd1;
   assign rsp_valid          = vld_ff[DivSteps];
   assign rsp_hue_out        = grey_ff[DivSteps] ? '0 : hue_ff[DivSteps].num[OutW-1:0];
   assign rsp_saturation_out = grey_ff[DivSteps] ? '0 : sat_ff[DivSteps].num[OutW-1:0];
   assign rsp_lightness_out  = light[16:1];

   a_idle_accepts: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[DivSteps] |-> !req_stall)
      else $error("input stalled while result stage empty");

   a_hold_front: assert property (@(posedge clock) disable iff (reset)
      vld1_ff && !en1 |=> vld1_ff)
      else $error("front stage lost an item");

   a_colour_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !grey_ff[DivSteps] |-> rsp_saturation_out != '0)
      else $error("zero saturation for a coloured pixel");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DivSteps] && rsp_stall |=> vld_ff[DivSteps])
      else $error("result dropped under stall");

endmodule

FILE: tb/tb_rgb_to_hsl_converter_core.sv
module tb_rgb_to_hsl_converter_core;
   import rhc_pkg::*;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [OutW-1:0] hue;
      logic [OutW-1:0] sat;
      logic [OutW-1:0] light;
   } hsl_type;

   localparam int CycleLimit = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [ChanW-1:0] req_red_in = '0;
   logic [ChanW-1:0] req_green_in = '0;
   logic [ChanW-1:0] req_blue_in = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [OutW-1:0]  rsp_hue_out;
   logic [OutW-1:0]  rsp_saturation_out;
   logic [OutW-1:0]  rsp_lightness_out;

   pixel_type pixel_q[$];
   hsl_type   hsl_expected_q[$];
   int        error_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 16;
   int        recv_idle_pct = 54;
   int        hold_off_cycles = 0;
   bit        hold_off_start = 1'b0;
   bit        hold_off_taken = 1'b0;
   bit        xfer_in = 1'b0;

   rgb_to_hsl_converter_core u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned round_div(longint unsigned num,
                                                 longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic hsl_type convert_pixel(pixel_type p);
      longint  r, g, b, mx, mn, d, sum, den, n;
      hsl_type o;
      r = p.red;
      g = p.green;
      b = p.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      sum = mx + mn;
      o.light = OutW'((sum * 257 + 1) / 2);
      o.hue = '0;
      o.sat = '0;
      if (d != 0) begin
         den = (sum < 255) ? sum : (510 - sum);
         o.sat = OutW'(round_div(d * 65535, den));
         if (r >= mx) n = g - b;
         else if (g >= mx) n = 2 * d + b - r;
         else n = 4 * d + r - g;
         if (n < 0) n += 6 * d;
         o.hue = OutW'(round_div(n * 65536, 6 * d));
      end
      return o;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      int        v;
      p = pixel_type'(24'($urandom));
      case ($urandom_range(0, 5))
         0: begin
            // grey
            p.green = p.red;
            p.blue = p.red;
         end
         1: p.green = p.red;
         2: p.blue = p.green;
         3: begin
            v = $urandom_range(0, 3);
            p.red = (v[0]) ? 8'hFF : 8'h00;
            p.green = (v[1]) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic push_pixel(input logic [7:0] r, g, b);
      pixel_q.push_back({r, g, b});
   endtask

   // driver
   always @(negedge clock) begin
      pixel_type p;
      if (!reset) begin
         if (!req_valid || xfer_in) begin
            if (pixel_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               p = pixel_q.pop_front();
               hsl_expected_q.push_back(convert_pixel(p));
               req_red_in <= p.red;
               req_green_in <= p.green;
               req_blue_in <= p.blue;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_start && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            hold_off_cycles = 120;
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles = hold_off_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      xfer_in <= req_valid && !req_stall && !reset;
   end

   // monitor
   always @(posedge clock) begin
      hsl_type act, exp_v;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         act = {rsp_hue_out, rsp_saturation_out, rsp_lightness_out};
         if (hsl_expected_q.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h", $realtime, act);
            error_count++;
         end else begin
            exp_v = hsl_expected_q.pop_front();
            if (act.hue !== exp_v.hue) begin
               $display("%0t: hue expected %h actual %h", $realtime, exp_v.hue, act.hue);
               error_count++;
            end
            if (act.sat !== exp_v.sat) begin
               $display("%0t: saturation expected %h actual %h", $realtime,
                        exp_v.sat, act.sat);
               error_count++;
            end
            if (act.light !== exp_v.light) begin
               $display("%0t: lightness expected %h actual %h", $realtime,
                        exp_v.light, act.light);
               error_count++;
            end
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pixel_q.size() > 0 || req_valid || hsl_expected_q.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int i;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // extremes, greys, each sector and the ties
      push_pixel(8'h00, 8'h00, 8'h00);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'h80, 8'h80, 8'h80);
      push_pixel(8'hFF, 8'h00, 8'h00);
      push_pixel(8'h00, 8'hFF, 8'h00);
      push_pixel(8'h00, 8'h00, 8'hFF);
      push_pixel(8'hFF, 8'hFF, 8'h00);
      push_pixel(8'h00, 8'hFF, 8'hFF);
      push_pixel(8'hFF, 8'h00, 8'hFF);
      push_pixel(8'hFF, 8'h00, 8'h01);
      push_pixel(8'h01, 8'h00, 8'h00);
      push_pixel(8'hFE, 8'hFF, 8'hFF);
      push_pixel(8'h7F, 8'h80, 8'h80);
      push_pixel(8'h80, 8'h7F, 8'h7F);
      push_pixel(8'h10, 8'h20, 8'h30);
      push_pixel(8'h30, 8'h10, 8'h20);
      push_pixel(8'h20, 8'h30, 8'h10);
      push_pixel(8'hAA, 8'h55, 8'hAA);
      wait_drained();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 54 : 0;
         recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 16 : 0;
         for (i = 0; i < 650; i++) pixel_q.push_back(random_pixel());
         if (ph == 1) hold_off_start = 1'b1;
         wait_drained();
         // sender pause with everything drained
         repeat (30) @(posedge clock);
      end
      repeat (60) @(posedge clock);
      if (error_count == 0 && hsl_expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
design/rhc_pkg.sv
design/rgb_to_hsl_converter_core.sv
tb/tb_rgb_to_hsl_converter_core.sv
